[rtl/lac_pkg.sv]
// Package for the lookahead compressor: constants, tables, register indexes.
package lac_pkg;

    localparam int DEPTH_DEFAULT       = 1024;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    localparam logic [23:0] UNITY_Q23        = 24'd8388608;
    localparam logic [24:0] COEF_ONE         = 25'd16777216;
    localparam logic [18:0] DB_PER_OCT_Q16   = 19'd394566;
    localparam logic [21:0] OCT_PER_DBQ8_Q16 = 22'd2786635;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_SLOPE     = 2'd1;
    localparam logic [1:0] REG_ATTACK    = 2'd2;
    localparam logic [1:0] REG_RELEASE   = 2'd3;

    localparam logic signed [15:0] THRESHOLD_RESET = -16'sd5120;
    localparam logic [15:0]        SLOPE_RESET     = 16'd56174;
    localparam logic [24:0]        ATTACK_RESET    = 25'd3804;
    localparam logic [24:0]        RELEASE_RESET   = 25'd761;

    function automatic logic [16:0] log2_seg(input logic [4:0] i);
        logic [16:0] r;
        begin
            case (i)
                5'd0:  r = 17'd0;
                5'd1:  r = 17'd5732;
                5'd2:  r = 17'd11136;
                5'd3:  r = 17'd16248;
                5'd4:  r = 17'd21098;
                5'd5:  r = 17'd25711;
                5'd6:  r = 17'd30109;
                5'd7:  r = 17'd34312;
                5'd8:  r = 17'd38336;
                5'd9:  r = 17'd42196;
                5'd10: r = 17'd45904;
                5'd11: r = 17'd49472;
                5'd12: r = 17'd52911;
                5'd13: r = 17'd56229;
                5'd14: r = 17'd59434;
                5'd15: r = 17'd62534;
                default: r = 17'd65536;
            endcase
            return r;
        end
    endfunction

    function automatic logic [16:0] exp2_seg(input logic [4:0] i);
        logic [16:0] r;
        begin
            case (i)
                5'd0:  r = 17'd65536;
                5'd1:  r = 17'd62757;
                5'd2:  r = 17'd60097;
                5'd3:  r = 17'd57549;
                5'd4:  r = 17'd55109;
                5'd5:  r = 17'd52773;
                5'd6:  r = 17'd50535;
                5'd7:  r = 17'd48393;
                5'd8:  r = 17'd46341;
                5'd9:  r = 17'd44376;
                5'd10: r = 17'd42495;
                5'd11: r = 17'd40694;
                5'd12: r = 17'd38968;
                5'd13: r = 17'd37316;
                5'd14: r = 17'd35734;
                5'd15: r = 17'd34219;
                default: r = 17'd32768;
            endcase
            return r;
        end
    endfunction

endpackage

[rtl/lookahead_compressor.sv]
// Lookahead feed-forward compressor: level detect, gain computer, envelope, delay line.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  s_axis   | s_axis_tvalid/s_axis_tready | tdata[15:0] sample_in
//  m_axis   | m_axis_tvalid/m_axis_tready | tdata[15:0] sample_out, [39:16] gain_now
//  cfg      | cfg_valid/cfg_ready         | cfg_index (register), cfg_data
//
// Each request walks the sequencer from acceptance to result; when the target gain is
// unity (zero sample or level not above threshold) the exp2 steps are skipped. The
// steps are the log2 lookup, dB conversion, slope, exp2 lookup, envelope and output
// multiply, one multiplier per step. No new request is taken until the result is
// posted and the sequencer is back in idle. The delay line is one synchronous RAM,
// read at the start of a request and written at its end.
// After reset a clearing pass writes zeros to all LOOKAHEAD_DEPTH entries, one per
// cycle; no request is taken until it completes. A finished result sits in the
// output register; the next request is taken while it waits, and holds in its last
// step until the output register is free.
module lookahead_compressor #(
    parameter int LOOKAHEAD_DEPTH = lac_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] sample_out, [39:16] gain_now
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [24:0] cfg_data
);

    localparam int AW = (LOOKAHEAD_DEPTH > 1) ? $clog2(LOOKAHEAD_DEPTH) : 1;
    localparam int SB = lac_pkg::SAMPLE_BITS_DEFAULT;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOG, S_DB, S_OVER, S_RED, S_OCT, S_EXP,
        S_EXPB, S_ENV, S_ENVB, S_OUT, S_OUTB, S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic signed [15:0] thr_reg;
    logic [15:0] slope_reg;
    logic [24:0] att_reg, rel_reg;

    // delay line
    logic signed [SB-1:0] line_mem [LOOKAHEAD_DEPTH];
    logic [AW-1:0] pos_reg;
    logic signed [SB-1:0] old_reg;
    logic signed [SB-1:0] samp_reg;

    logic [23:0] env_reg;
    logic [23:0] dest_reg;
    logic [23:0] mag_reg;       // |sample|
    logic [4:0]  e_reg;
    logic [22:0] frac_reg;
    logic [20:0] logq_reg;      // log2 Q16
    logic signed [25:0] over_reg;
    logic [25:0] red_reg;
    logic [31:0] oct_reg;
    logic [16:0] ev_reg;
    logic [47:0] prod_reg;
    logic        dn_reg;
    logic [15:0] out_s_reg;
    logic        mvalid_reg;

    // ---- combinational helpers ----
    logic [4:0]  msb_pos;
    always_comb
    begin
        msb_pos = 5'd0;
        for (int i = 1; i < 24; i++)
        begin
            if (mag_reg[i]) msb_pos = 5'(i);
        end
    end

    logic [23:0] mag_in;
    logic signed [SB-1:0] s_in;
    assign s_in   = s_axis_tdata[SB-1:0];
    assign mag_in = s_in[SB-1] ? 24'(-{{(24-SB){s_in[SB-1]}}, s_in})
                               : 24'({{(24-SB){1'b0}}, s_in});

    // log2 interpolation
    logic [3:0]  lidx;
    logic [18:0] lrem;
    logic [16:0] lbase, lnext;
    logic [36:0] lprod;
    assign lidx  = frac_reg[22:19];
    assign lrem  = frac_reg[18:0];
    assign lbase = lac_pkg::log2_seg({1'b0, lidx});
    assign lnext = lac_pkg::log2_seg({1'b0, lidx} + 5'd1);
    assign lprod = 37'(lnext - lbase) * 37'(lrem);

    // exp2 interpolation
    logic [3:0]  xidx;
    logic [11:0] xrem;
    logic [16:0] xbase, xnext;
    logic [28:0] xprod;
    assign xidx  = oct_reg[15:12];
    assign xrem  = oct_reg[11:0];
    assign xbase = lac_pkg::exp2_seg({1'b0, xidx});
    assign xnext = lac_pkg::exp2_seg({1'b0, xidx} + 5'd1);
    assign xprod = 29'(xbase - xnext) * 29'(xrem);

    logic [24:0] ac, rc;
    assign ac = (att_reg > lac_pkg::COEF_ONE) ? lac_pkg::COEF_ONE : att_reg;
    assign rc = (rel_reg > lac_pkg::COEF_ONE) ? lac_pkg::COEF_ONE : rel_reg;

    logic [23:0] old_mag;
    assign old_mag = old_reg[SB-1] ? 24'(-{{(24-SB){old_reg[SB-1]}}, old_reg})
                                   : 24'({{(24-SB){1'b0}}, old_reg});

    logic [SB-1:0] hi_val;
    assign hi_val = {1'b0, {(SB-1){1'b1}}};

    logic in_acc, out_acc;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign cfg_ready = 1'b1;

    // memory: read at accept, write during clear or at finish
    logic [AW-1:0] clr_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            line_mem[clr_reg] <= '0;
        else if (state_reg == S_DONE)
            line_mem[pos_reg] <= samp_reg;
        if (in_acc)
            old_reg <= line_mem[pos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            pos_reg    <= '0;
            env_reg    <= lac_pkg::UNITY_Q23;
            mvalid_reg <= 1'b0;
            thr_reg    <= lac_pkg::THRESHOLD_RESET;
            slope_reg  <= lac_pkg::SLOPE_RESET;
            att_reg    <= lac_pkg::ATTACK_RESET;
            rel_reg    <= lac_pkg::RELEASE_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    lac_pkg::REG_THRESHOLD: thr_reg   <= cfg_data[15:0];
                    lac_pkg::REG_SLOPE:     slope_reg <= cfg_data[15:0];
                    lac_pkg::REG_ATTACK:    att_reg   <= cfg_data;
                    lac_pkg::REG_RELEASE:   rel_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (out_acc)
                mvalid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == LOOKAHEAD_DEPTH - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        samp_reg  <= s_in;
                        mag_reg   <= mag_in;
                        state_reg <= S_LOG;
                    end
                end
                S_LOG:
                begin
                    e_reg     <= msb_pos;
                    frac_reg  <= 23'(mag_reg << (5'd23 - msb_pos));
                    state_reg <= S_DB;
                end
                S_DB:
                begin
                    logq_reg  <= 21'({e_reg, 16'd0}) + 21'(lbase) + 21'(lprod >> 19);
                    state_reg <= S_OVER;
                end
                S_OVER:
                begin
                    // attenuation octaves times dB per octave
                    prod_reg  <= 48'(21'(SB - 1) * 21'h10000 - logq_reg)
                                 * 48'(lac_pkg::DB_PER_OCT_Q16);
                    state_reg <= S_RED;
                end
                S_RED:
                begin
                    over_reg  <= 26'sd0 - 26'($signed({1'b0, 24'((prod_reg + 48'h800000) >> 24)}))
                                 - 26'(thr_reg);
                    state_reg <= S_OCT;
                end
                S_OCT:
                begin
                    if (mag_reg == 24'd0 || over_reg <= 0)
                    begin
                        dest_reg  <= lac_pkg::UNITY_Q23;
                        state_reg <= S_ENV;
                    end
                    else
                    begin
                        red_reg   <= 26'((42'(over_reg) * 42'(slope_reg)) >> 16);
                        state_reg <= S_EXP;
                    end
                end
                S_EXP:
                begin
                    oct_reg   <= 32'((48'(red_reg) * 48'(lac_pkg::OCT_PER_DBQ8_Q16)
                                      + 48'd32768) >> 16);
                    state_reg <= S_EXPB;
                end
                S_EXPB:
                begin
                    if (oct_reg[31:16] >= 16'd24)
                        dest_reg <= 24'd0;
                    else
                        dest_reg <= 24'({(xbase - 17'(xprod >> 12)), 7'd0} >> oct_reg[20:16]);
                    state_reg <= S_ENV;
                end
                S_ENV:
                begin
                    dn_reg <= env_reg > dest_reg;
                    if (env_reg > dest_reg)
                        prod_reg <= 48'(env_reg - dest_reg) * 48'(ac);
                    else
                        prod_reg <= 48'(dest_reg - env_reg) * 48'(rc);
                    state_reg <= S_ENVB;
                end
                S_ENVB:
                begin
                    env_reg   <= dn_reg ? env_reg - 24'(prod_reg >> 24)
                                        : env_reg + 24'(prod_reg >> 24);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    prod_reg  <= 48'(old_mag) * 48'(env_reg) + 48'h400000;
                    state_reg <= S_OUTB;
                end
                S_OUTB:
                begin
                    // saturate magnitude then apply sign
                    if (old_reg[SB-1])
                        out_s_reg <= ((prod_reg >> 23) > 48'(hi_val) + 48'd1)
                            ? 16'(~hi_val) : 16'(-(prod_reg >> 23));
                    else
                        out_s_reg <= ((prod_reg >> 23) > 48'(hi_val))
                            ? 16'(hi_val) : 16'(prod_reg >> 23);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!mvalid_reg || out_acc)
                    begin
                        mvalid_reg <= 1'b1;
                        m_axis_tdata <= {env_reg, out_s_reg};
                        pos_reg   <= (32'(pos_reg) == LOOKAHEAD_DEPTH - 1) ? '0 : pos_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = mvalid_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
        env_reg <= lac_pkg::UNITY_Q23) else $error("envelope above unity");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
`endif

endmodule
